>>> hw/rtl/apcd_pkg.sv
// ----------------------------------------------------------------------------
// Application pack deframer package
// Phase type, header lengths and field positions inside the file header.
// ----------------------------------------------------------------------------
package apcd_pkg;

   // Parse phase of the archive stream
   typedef enum logic [1:0] {
      PH_PACK_HDR = 2'd0,
      PH_FILE_HDR = 2'd1,
      PH_PAYLOAD  = 2'd2,
      PH_DONE     = 2'd3
   } phase_type;

   localparam int HDR_CNT_W = 6;

   // Index of the last byte of each header (lengths 8 and 52 bytes)
   localparam logic [HDR_CNT_W-1:0] PACK_HDR_LAST = 6'd7;
   localparam logic [HDR_CNT_W-1:0] FILE_HDR_LAST = 6'd51;

   // Positions within the pack header
   localparam logic [HDR_CNT_W-1:0] POS_COUNT_LO = 6'd0;
   localparam logic [HDR_CNT_W-1:0] POS_COUNT_HI = 6'd1;

   // Positions within the file header (name occupies bytes 0 to 31)
   localparam logic [HDR_CNT_W-1:0] POS_TYPE     = 6'd32;
   localparam logic [HDR_CNT_W-1:0] POS_SIZE_0   = 6'd33;
   localparam logic [HDR_CNT_W-1:0] POS_SIZE_1   = 6'd34;
   localparam logic [HDR_CNT_W-1:0] POS_SIZE_2   = 6'd35;
   localparam logic [HDR_CNT_W-1:0] POS_MD5_HI   = 6'd36;
   localparam logic [HDR_CNT_W-1:0] POS_MD5_LO   = 6'd44;

   // Result word layout
   localparam int RSP_DATA_W = 216;
   localparam int RSP_USER_W = 1;

endpackage

>>> hw/rtl/app_pack_container_deframer_unit.sv
// ----------------------------------------------------------------------------
// Application pack deframer
// Parses the pack header and per-file headers of a byte stream and forwards
// each payload byte with its file attributes and expected digest.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                      | tdata / tuser / tlast
//  --------+-----+---------------------------+-------------------------------
//  req_    | in  | one archive byte          | tdata[7:0] data_byte
//  rsp_    | out | one payload byte or empty | tdata see port, tuser has_byte,
//          |     | file marker               | tlast last_in_file
//
//  One byte is taken in every cycle unless the result register stalls; each
//  result passes the input register, then the result register. No result
//  comes from header bytes, bar the last of an empty file, or after the pack.
//  A stalled result register holds the byte in the input register; req_tready
//  drops only while both registers are full and rsp_tready is low.
//  Synchronous reset returns the parser to the pack header.
//
module app_pack_container_deframer_unit (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] data_byte
   input  logic [7:0]                       req_tdata,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] payload_byte, [31:8] byte_offset, [55:32] declared_size,
   // [63:56] type_byte, [79:64] file_number, [143:80] md5_high,
   // [207:144] md5_low, [208] last_in_pack, [215:209] zero
   output logic [apcd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] has_byte
   output logic [apcd_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast
);

   // Input register
   logic                              in_vld_ff, in_vld_in;
   logic [7:0]                        in_byte_ff, in_byte_in;

   // Parser state
   apcd_pkg::phase_type               phase_ff, phase_in;
   logic [apcd_pkg::HDR_CNT_W-1:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [15:0]                       files_left_ff, files_left_in;
   logic [7:0]                        type_ff, type_in;
   logic [23:0]                       size_ff, size_in;
   logic [63:0]                       md5_hi_ff, md5_hi_in;
   logic [63:0]                       md5_lo_ff, md5_lo_in;
   logic [23:0]                       pay_cnt_ff, pay_cnt_in;
   logic [15:0]                       file_idx_ff, file_idx_in;

   // Result register
   logic                              out_vld_ff, out_vld_in;
   logic [apcd_pkg::RSP_DATA_W-1:0]   out_data_ff, out_data_in;
   logic                              out_has_ff, out_has_in;
   logic                              out_last_ff, out_last_in;

   logic                              out_free;
   logic                              step;
   logic                              emit;
   logic                              has_byte;
   logic [23:0]                       offs_inc;
   logic                              last_file;
   logic [15:0]                       files_dec;
   logic                              last_pack;
   logic                              file_hdr_end;
   logic [apcd_pkg::HDR_CNT_W-1:0]    pos_inc;

   // Handshake: work on the held byte whenever the result register can take it
   assign out_free   = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   assign in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_vld_ff);
   assign in_byte_in = (req_tvalid && req_tready) ? req_tdata : in_byte_ff;

   // Shared decode of file completion
   assign pos_inc      = hdr_cnt_ff + 1'b1;
   assign file_hdr_end = (phase_ff == apcd_pkg::PH_FILE_HDR) &&
                         (hdr_cnt_ff == apcd_pkg::FILE_HDR_LAST);
   assign has_byte     = (phase_ff == apcd_pkg::PH_PAYLOAD);
   assign emit         = step && (has_byte || (file_hdr_end && size_ff == 24'd0));
   assign offs_inc     = pay_cnt_ff + 24'd1;
   assign last_file    = has_byte ? (offs_inc == size_ff) : 1'b1;
   assign files_dec    = files_left_ff - 16'd1;
   assign last_pack    = last_file && (files_dec == 16'd0);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            apcd_pkg::PH_PACK_HDR: begin
               if (hdr_cnt_ff == apcd_pkg::PACK_HDR_LAST) begin
                  phase_in = apcd_pkg::PH_FILE_HDR;
               end
            end
            apcd_pkg::PH_FILE_HDR: begin
               if (file_hdr_end) begin
                  if (!emit) begin
                     phase_in = apcd_pkg::PH_PAYLOAD;
                  end else if (last_pack) begin
                     phase_in = apcd_pkg::PH_DONE;
                  end
               end
            end
            apcd_pkg::PH_PAYLOAD: begin
               if (last_file) begin
                  phase_in = last_pack ? apcd_pkg::PH_DONE : apcd_pkg::PH_FILE_HDR;
               end
            end
            apcd_pkg::PH_DONE: begin
               phase_in = apcd_pkg::PH_DONE;
            end
            default: begin
               phase_in = apcd_pkg::PH_DONE;
            end
         endcase
      end
   end

   // Header capture, counters and result word
   always_comb begin
      hdr_cnt_in    = hdr_cnt_ff;
      files_left_in = files_left_ff;
      type_in       = type_ff;
      size_in       = size_ff;
      md5_hi_in     = md5_hi_ff;
      md5_lo_in     = md5_lo_ff;
      pay_cnt_in    = pay_cnt_ff;
      file_idx_in   = file_idx_ff;

      if (step) begin
         unique case (phase_ff)
            apcd_pkg::PH_PACK_HDR: begin
               if (hdr_cnt_ff == apcd_pkg::POS_COUNT_LO) begin
                  files_left_in = {8'd0, in_byte_ff};
               end else if (hdr_cnt_ff == apcd_pkg::POS_COUNT_HI) begin
                  files_left_in = {in_byte_ff, files_left_ff[7:0]};
               end
               hdr_cnt_in = (hdr_cnt_ff == apcd_pkg::PACK_HDR_LAST) ? '0 : pos_inc;
            end
            apcd_pkg::PH_FILE_HDR: begin
               priority if (hdr_cnt_ff == apcd_pkg::POS_TYPE) begin
                  type_in = in_byte_ff;
               end else if (hdr_cnt_ff == apcd_pkg::POS_SIZE_0) begin
                  size_in = {16'd0, in_byte_ff};
               end else if (hdr_cnt_ff == apcd_pkg::POS_SIZE_1) begin
                  size_in = {8'd0, in_byte_ff, size_ff[7:0]};
               end else if (hdr_cnt_ff == apcd_pkg::POS_SIZE_2) begin
                  size_in = {in_byte_ff, size_ff[15:0]};
               end else if (hdr_cnt_ff >= apcd_pkg::POS_MD5_HI &&
                            hdr_cnt_ff <  apcd_pkg::POS_MD5_LO) begin
                  md5_hi_in = {md5_hi_ff[55:0], in_byte_ff};
               end else if (hdr_cnt_ff >= apcd_pkg::POS_MD5_LO) begin
                  md5_lo_in = {md5_lo_ff[55:0], in_byte_ff};
               end else begin
                  type_in = type_ff;
               end
               if (file_hdr_end) begin
                  hdr_cnt_in = '0;
                  pay_cnt_in = '0;
               end else begin
                  hdr_cnt_in = pos_inc;
               end
            end
            apcd_pkg::PH_PAYLOAD: begin
               pay_cnt_in = offs_inc;
            end
            apcd_pkg::PH_DONE: begin
               hdr_cnt_in = hdr_cnt_ff;
            end
            default: begin
               hdr_cnt_in = hdr_cnt_ff;
            end
         endcase

         // Close the file on its final result
         if (emit && last_file) begin
            files_left_in = files_dec;
            file_idx_in   = file_idx_ff + 16'd1;
            hdr_cnt_in    = '0;
            pay_cnt_in    = '0;
         end
      end
   end

   // Result register load
   always_comb begin
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_has_in  = out_has_ff;
      out_last_in = out_last_ff;
      if (emit) begin
         out_vld_in  = 1'b1;
         out_has_in  = has_byte;
         out_last_in = last_file;
         out_data_in = {7'd0,
                        last_pack,
                        md5_lo_in,
                        md5_hi_in,
                        file_idx_ff,
                        type_in,
                        size_in,
                        has_byte ? pay_cnt_ff : 24'd0,
                        has_byte ? in_byte_ff : 8'd0};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         phase_ff      <= apcd_pkg::PH_PACK_HDR;
         hdr_cnt_ff    <= '0;
         files_left_ff <= '0;
         type_ff       <= '0;
         size_ff       <= '0;
         pay_cnt_ff    <= '0;
         file_idx_ff   <= '0;
      end else begin
         in_vld_ff     <= in_vld_in;
         out_vld_ff    <= out_vld_in;
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         files_left_ff <= files_left_in;
         type_ff       <= type_in;
         size_ff       <= size_in;
         pay_cnt_ff    <= pay_cnt_in;
         file_idx_ff   <= file_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      md5_hi_ff   <= md5_hi_in;
      md5_lo_ff   <= md5_lo_in;
      out_data_ff <= out_data_in;
      out_has_ff  <= out_has_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_has_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
